// File: rtl/core/masked_signature_scanner_core_defines.svh
// assertion macros shared by the scanner core modules
// no dependencies; included by the files that check their own logic
`ifndef MASKED_SIGNATURE_SCANNER_CORE_DEFINES_SVH
`define MASKED_SIGNATURE_SCANNER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MSSC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property failed");
`define MSSC_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define MSSC_ASSERT(label, clk, rst_n, prop)
`define MSSC_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/core/mssc_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the masked signature scanner core
// no dependencies
package mssc_pkg;

  localparam int MAX_SIG_LEN_DEF = 48;
  localparam int ADDR_BITS_DEF   = 48;

  // signature register file geometry
  localparam int SIG_BYTES  = 48;
  localparam int SIG_REGS   = 6;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int LEN_REG_W  = 6;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_ONE   = 2'd1,
    ST_MULTI = 2'd2
  } match_status_t;

endpackage

// File: rtl/core/mssc_cfg.sv
`timescale 1ns / 1ps
// apb register file: signature bytes, care mask, length
// also keeps a length-aligned copy of signature and mask for the window compare; uses mssc_pkg
module mssc_cfg #(
  parameter  int MAX_SIG_LEN = mssc_pkg::MAX_SIG_LEN_DEF,
  localparam int LEN_W       = $clog2(MAX_SIG_LEN + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mssc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mssc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mssc_pkg::CFG_DATA_W-1:0] prdata,
  output logic [MAX_SIG_LEN*8-1:0]        align_sig,
  output logic [MAX_SIG_LEN-1:0]          align_care,
  output logic [LEN_W-1:0]                eff_len
);

  localparam logic [2:0] REG_CARE = 3'd6;
  localparam logic [2:0] REG_LEN  = 3'd7;

  logic [mssc_pkg::CFG_DATA_W-1:0] sig_r   [mssc_pkg::SIG_REGS];
  logic [mssc_pkg::CFG_DATA_W-1:0] sig_nxt [mssc_pkg::SIG_REGS];
  logic [mssc_pkg::SIG_BYTES-1:0]  care_r, care_nxt;
  logic [mssc_pkg::LEN_REG_W-1:0]  len_r, len_nxt;
  logic [2:0]                      reg_idx;
  logic                            wr_en;

  logic [7:0]                      sigx [64];
  logic [63:0]                     carex;
  logic [6:0]                      eff_ext;
  logic [6:0]                      k;
  logic [MAX_SIG_LEN*8-1:0]        align_sig_nxt, align_sig_r;
  logic [MAX_SIG_LEN-1:0]          align_care_nxt, align_care_r;
  logic [LEN_W-1:0]                eff_nxt, eff_r;

  assign reg_idx = paddr[5:3];
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    sig_nxt  = sig_r;
    care_nxt = care_r;
    len_nxt  = len_r;
    if (!rst_n) begin
      for (int r = 0; r < mssc_pkg::SIG_REGS; r++) sig_nxt[r] = '0;
      care_nxt = '1;
      len_nxt  = mssc_pkg::LEN_REG_W'(mssc_pkg::SIG_BYTES);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CARE: care_nxt = pwdata[mssc_pkg::SIG_BYTES-1:0];
        REG_LEN:  len_nxt  = pwdata[mssc_pkg::LEN_REG_W-1:0];
        default:  sig_nxt[reg_idx] = pwdata;
      endcase
    end
  end

  // aligned copy follows the next register values so it changes together with the registers
  always_comb begin
    for (int j = 0; j < 64; j++) sigx[j] = '0;
    for (int r = 0; r < mssc_pkg::SIG_REGS; r++) begin
      for (int b = 0; b < 8; b++) sigx[r*8 + b] = sig_nxt[r][b*8 +: 8];
    end
    carex = 64'(care_nxt);

    if (len_nxt == '0) begin
      eff_ext = 7'd1;
    end else if ({1'b0, len_nxt} > 7'(MAX_SIG_LEN)) begin
      eff_ext = 7'(MAX_SIG_LEN);
    end else begin
      eff_ext = {1'b0, len_nxt};
    end
    eff_nxt = LEN_W'(eff_ext);

    // window position p (0 = newest) lines up with signature byte len-1-p
    for (int p = 0; p < MAX_SIG_LEN; p++) begin
      k = eff_ext - 7'd1 - 7'(p);
      if (7'(p) < eff_ext) begin
        align_sig_nxt[p*8 +: 8] = sigx[k[5:0]];
        align_care_nxt[p]       = carex[k[5:0]];
      end else begin
        align_sig_nxt[p*8 +: 8] = '0;
        align_care_nxt[p]       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sig_r        <= sig_nxt;
    care_r       <= care_nxt;
    len_r        <= len_nxt;
    align_sig_r  <= align_sig_nxt;
    align_care_r <= align_care_nxt;
    eff_r        <= eff_nxt;
  end

  always_comb begin
    unique case (reg_idx)
      REG_CARE: prdata = mssc_pkg::CFG_DATA_W'(care_r);
      REG_LEN:  prdata = mssc_pkg::CFG_DATA_W'(len_r);
      default:  prdata = sig_r[reg_idx];
    endcase
  end

  assign align_sig  = align_sig_r;
  assign align_care = align_care_r;
  assign eff_len    = eff_r;

endmodule

// File: rtl/core/mssc_front.sv
`timescale 1ns / 1ps
// front end: takes bytes, keeps the sliding window, classifies each byte as hit or miss
// pushes {last, hit, start address} into the queue; uses mssc_pkg for defaults
module mssc_front #(
  parameter  int MAX_SIG_LEN = mssc_pkg::MAX_SIG_LEN_DEF,
  parameter  int ADDR_BITS   = mssc_pkg::ADDR_BITS_DEF,
  localparam int LEN_W       = $clog2(MAX_SIG_LEN + 1),
  localparam int ENTRY_W     = ADDR_BITS + 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte,
  input  logic [ADDR_BITS-1:0]     in_addr,
  input  logic                     in_last,
  input  logic [MAX_SIG_LEN*8-1:0] align_sig,
  input  logic [MAX_SIG_LEN-1:0]   align_care,
  input  logic [LEN_W-1:0]         eff_len,
  input  logic                     q_full,
  output logic                     push,
  output logic [ENTRY_W-1:0]       push_data
);

  logic [7:0]             win_r [MAX_SIG_LEN];
  logic [LEN_W-1:0]       seen_r, seen_nxt;
  logic [ADDR_BITS-1:0]   addr_r;
  logic                   last_r;
  logic                   valid_r, valid_nxt;
  logic                   acc;
  logic [MAX_SIG_LEN-1:0] pos_ok;
  logic                   hit;
  logic [ADDR_BITS-1:0]   start_addr;

  assign in_ready = !valid_r || !q_full;
  assign acc      = in_valid && in_ready;
  assign push     = valid_r && !q_full;

  always_comb begin
    valid_nxt = valid_r;
    if (acc) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  // byte count restarts after the byte that closed the previous region
  always_comb begin
    seen_nxt = seen_r;
    if (acc) begin
      priority if (last_r) begin
        seen_nxt = LEN_W'(1);
      end else if (seen_r != LEN_W'(MAX_SIG_LEN)) begin
        seen_nxt = seen_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      seen_r  <= '0;
      last_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      seen_r  <= seen_nxt;
      if (acc) last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      win_r[0] <= in_byte;
      for (int i = 1; i < MAX_SIG_LEN; i++) win_r[i] <= win_r[i-1];
      addr_r <= in_addr;
    end
  end

  always_comb begin
    for (int p = 0; p < MAX_SIG_LEN; p++) begin
      pos_ok[p] = !align_care[p] || (win_r[p] == align_sig[p*8 +: 8]);
    end
  end

  // bytes older than the region never count: the region must have supplied eff_len bytes first
  assign hit        = (seen_r >= eff_len) && (&pos_ok);
  assign start_addr = addr_r - ADDR_BITS'(eff_len) + ADDR_BITS'(1);
  assign push_data  = {last_r, hit, start_addr};

endmodule

// File: rtl/core/mssc_queue.sv
`timescale 1ns / 1ps
// small flop-based fifo between the front and back ends
// depth from mssc_pkg; assertion macros from the core defines header
`include "masked_signature_scanner_core_defines.svh"
module mssc_queue #(
  parameter int WIDTH = mssc_pkg::ADDR_BITS_DEF + 2,
  parameter int DEPTH = mssc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  `MSSC_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full)
  `MSSC_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && empty)

endmodule

// File: rtl/core/mssc_back.sv
`timescale 1ns / 1ps
// back end: tallies hits per region and emits the region result on its last byte
// uses mssc_pkg status codes and the core assertion macros
`include "masked_signature_scanner_core_defines.svh"
module mssc_back #(
  parameter  int ADDR_BITS = mssc_pkg::ADDR_BITS_DEF,
  localparam int ENTRY_W   = ADDR_BITS + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  logic [ENTRY_W-1:0]   q_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ADDR_BITS-1:0] out_addr,
  output logic [1:0]           out_status
);

  logic                    e_last, e_hit;
  logic [ADDR_BITS-1:0]    e_start;
  mssc_pkg::match_status_t tally_r, tally_upd;
  logic [ADDR_BITS-1:0]    latest_r, latest_upd;
  logic                    out_valid_r;
  logic [ADDR_BITS-1:0]    out_addr_r;
  mssc_pkg::match_status_t out_status_r;
  logic                    out_free;
  logic                    emit;

  assign {e_last, e_hit, e_start} = q_data;

  assign out_free = !out_valid_r || out_ready;
  assign pop      = !q_empty && (!e_last || out_free);
  assign emit     = pop && e_last;

  // tally saturates at several
  always_comb begin
    tally_upd = tally_r;
    if (e_hit) begin
      unique case (tally_r)
        mssc_pkg::ST_NONE: tally_upd = mssc_pkg::ST_ONE;
        default:           tally_upd = mssc_pkg::ST_MULTI;
      endcase
    end
    latest_upd = e_hit ? e_start : latest_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r     <= mssc_pkg::ST_NONE;
      latest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        tally_r     <= mssc_pkg::ST_NONE;
        latest_r    <= '0;
        out_valid_r <= 1'b1;
      end else begin
        if (pop) begin
          tally_r  <= tally_upd;
          latest_r <= latest_upd;
        end
        if (out_ready) out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= tally_upd;
      out_addr_r   <= (tally_upd == mssc_pkg::ST_ONE) ? latest_upd : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_addr   = out_addr_r;
  assign out_status = out_status_r;

  `MSSC_ASSERT(a_region_clears, clk, rst_n, emit |=> (tally_r == mssc_pkg::ST_NONE && out_valid_r))
  `MSSC_ASSERT(a_addr_only_unique, clk, rst_n, (out_valid_r && out_status_r != mssc_pkg::ST_ONE) |-> out_addr_r == '0)
  `MSSC_ASSERT(a_no_emit_over_result, clk, rst_n, (out_valid_r && !out_ready) |-> !emit)

endmodule

// File: rtl/core/masked_signature_scanner_core.sv
`timescale 1ns / 1ps
// top level of the masked signature scanner core
// instantiates mssc_cfg, mssc_front, mssc_queue and mssc_back; uses mssc_pkg
//
//   port group   dir   role
//   in_*         in    region bytes with address, tlast marks the region end
//   out_*        out   one result per region: match address and status
//   cfg_*        in    apb register port, 64-bit data, registers at 8*i
//
// one byte per cycle sustained while the queue is not full.
// a result passes the window register, the queue and the output register after its last byte is accepted.
// rst_n is synchronous; no clearing pass, the block takes bytes as soon as reset is released.
// a stalled output backs up the queue before in_tready drops.
module masked_signature_scanner_core #(
  parameter  int MAX_SIG_LEN = mssc_pkg::MAX_SIG_LEN_DEF,
  parameter  int ADDR_BITS   = mssc_pkg::ADDR_BITS_DEF,
  localparam int IN_W        = ((8 + ADDR_BITS + 7) / 8) * 8,
  localparam int OUT_W       = ((ADDR_BITS + 2 + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_W-1:0]                 in_tdata,    // data_byte, byte_address
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_W-1:0]                out_tdata,   // match_address, match_status
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [mssc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [mssc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [mssc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int LEN_W   = $clog2(MAX_SIG_LEN + 1);
  localparam int ENTRY_W = ADDR_BITS + 2;

  logic [MAX_SIG_LEN*8-1:0] align_sig;
  logic [MAX_SIG_LEN-1:0]   align_care;
  logic [LEN_W-1:0]         eff_len;
  logic                     q_push, q_pop, q_full, q_empty;
  logic [ENTRY_W-1:0]       q_wdata, q_rdata;
  logic [ADDR_BITS-1:0]     res_addr;
  logic [1:0]               res_status;

  assign cfg_pready = 1'b1;

  mssc_cfg #(
    .MAX_SIG_LEN (MAX_SIG_LEN)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .align_sig  (align_sig),
    .align_care (align_care),
    .eff_len    (eff_len)
  );

  mssc_front #(
    .MAX_SIG_LEN (MAX_SIG_LEN),
    .ADDR_BITS   (ADDR_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata[7:0]),
    .in_addr    (in_tdata[8 +: ADDR_BITS]),
    .in_last    (in_tlast),
    .align_sig  (align_sig),
    .align_care (align_care),
    .eff_len    (eff_len),
    .q_full     (q_full),
    .push       (q_push),
    .push_data  (q_wdata)
  );

  mssc_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (mssc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  mssc_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_addr   (res_addr),
    .out_status (res_status)
  );

  assign out_tdata = OUT_W'({res_status, res_addr});

endmodule

// File: test/signature_scan_checker.sv
`timescale 1ns / 1ps
// scoreboard for the masked signature scanner core: follows register writes and region
// bytes, predicts the report of each region and compares it with the result channel
// depends on mssc_pkg; also holds the register map shared with the testbench top
package scan_regs_pkg;

  localparam int REG_SIG_FIRST = 0;
  localparam int REG_CARE      = 6;
  localparam int REG_LEN       = 7;
  localparam int REG_STRIDE    = 8;

endpackage

module signature_scan_checker #(
  parameter int IN_W  = 56,
  parameter int OUT_W = 56
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [IN_W-1:0]                 in_tdata,    // data_byte, byte_address
  input  logic                            in_tlast,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [OUT_W-1:0]                out_tdata,   // match_address, match_status
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic                            cfg_pready,
  input  logic [mssc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [mssc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output int                              mismatches,
  output int                              reports_pending
);

  typedef struct packed {
    logic [47:0]             start_addr;
    mssc_pkg::match_status_t status;
  } region_report_t;

  logic [63:0]             sig_word [mssc_pkg::SIG_REGS];
  logic [47:0]             care_bits;
  logic [5:0]              len_field;
  logic [7:0]              window [mssc_pkg::SIG_BYTES];
  int                      seen;
  mssc_pkg::match_status_t tally;
  logic [47:0]             latest_start;
  region_report_t          expected_reports [$];

  initial begin
    mismatches      = 0;
    reports_pending = 0;
  end

  function automatic void clear_scan();
    foreach (window[i]) window[i] = '0;
    seen         = 0;
    tally        = mssc_pkg::ST_NONE;
    latest_start = '0;
  endfunction

  always @(posedge clk) begin : scan_predict
    int             reg_index;
    int             n;
    logic           hit;
    logic [47:0]    got_addr;
    logic [1:0]     got_status;
    region_report_t due;
    if (!rst_n) begin
      foreach (sig_word[i]) sig_word[i] = '0;
      care_bits = '1;
      len_field = 6'd48;
      clear_scan();
      expected_reports.delete();
    end else begin
      // result side first: a request accepted now cannot have its report out yet
      if (out_tvalid && out_tready) begin
        got_addr   = out_tdata[47:0];
        got_status = out_tdata[49:48];
        if (expected_reports.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected report, expected none, got address %h status %0d",
                   $time, got_addr, got_status);
        end else begin
          due = expected_reports.pop_front();
          if (got_addr !== due.start_addr) begin
            mismatches++;
            $display("%0t: match_address expected %h, got %h", $time, due.start_addr, got_addr);
          end
          if (got_status !== due.status) begin
            mismatches++;
            $display("%0t: match_status expected %0d, got %0d", $time, due.status, got_status);
          end
        end
      end

      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[2:0] == 3'd0) begin
        reg_index = cfg_paddr / scan_regs_pkg::REG_STRIDE;
        if (reg_index < scan_regs_pkg::REG_CARE)
          sig_word[reg_index - scan_regs_pkg::REG_SIG_FIRST] = cfg_pwdata;
        else if (reg_index == scan_regs_pkg::REG_CARE)
          care_bits = cfg_pwdata[47:0];
        else if (reg_index == scan_regs_pkg::REG_LEN)
          len_field = cfg_pwdata[5:0];
      end

      if (in_tvalid && in_tready) begin
        // zero length acts as one, anything beyond the window as the full window
        if (len_field == 6'd0)
          n = 1;
        else if (len_field > mssc_pkg::SIG_BYTES)
          n = mssc_pkg::SIG_BYTES;
        else
          n = int'(len_field);
        for (int k = mssc_pkg::SIG_BYTES - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = in_tdata[7:0];
        if (seen < mssc_pkg::SIG_BYTES) seen++;
        if (seen >= n) begin
          hit = 1'b1;
          // signature byte k lines up with the byte taken n-1-k requests ago
          for (int k = 0; k < n; k++)
            if (care_bits[k] && window[n-1-k] != sig_word[k/8][(k%8)*8 +: 8]) hit = 1'b0;
          if (hit) begin
            tally = (tally == mssc_pkg::ST_NONE) ? mssc_pkg::ST_ONE : mssc_pkg::ST_MULTI;
            latest_start = in_tdata[55:8] - 48'(n - 1);
          end
        end
        if (in_tlast) begin
          due.start_addr = (tally == mssc_pkg::ST_ONE) ? latest_start : '0;
          due.status     = tally;
          expected_reports.push_back(due);
          clear_scan();
        end
      end
    end
    reports_pending = expected_reports.size();
  end

endmodule

// File: test/tb_masked_signature_scanner_core.sv
`timescale 1ns / 1ps
// testbench top for masked_signature_scanner_core: directed and random regions
// with planted, broken and wildcard signatures; verdict from signature_scan_checker
// depends on mssc_pkg, scan_regs_pkg and signature_scan_checker
module tb_masked_signature_scanner_core;

  localparam int ADDR_W       = mssc_pkg::ADDR_BITS_DEF;
  localparam int IN_W         = ((8 + ADDR_W + 7) / 8) * 8;
  localparam int OUT_W        = ((ADDR_W + 2 + 7) / 8) * 8;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 700;
  localparam int REGION_MAX   = 64;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [IN_W-1:0]                 in_tdata;    // data_byte, byte_address
  logic                            in_tlast;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [OUT_W-1:0]                out_tdata;   // match_address, match_status
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [mssc_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [mssc_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [mssc_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  int          send_idle = 24;
  int          recv_idle = 52;
  int          mismatches;
  int          reports_pending;
  int          quiet_cycles = 0;
  int          bytes_sent = 0;
  logic [7:0]  sig_pat [mssc_pkg::SIG_BYTES];
  logic [47:0] care_now;
  int          sig_len;
  logic [47:0] next_addr;

  masked_signature_scanner_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  signature_scan_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) scan_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .mismatches      (mismatches),
    .reports_pending (reports_pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance with valid still up
  task automatic push_byte(input logic [7:0] data_byte, input logic last_byte);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {next_addr, data_byte};
    in_tlast  <= last_byte;
    next_addr = next_addr + 48'd1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // hold off the sender until every report is in and the pipeline has drained
  task automatic settle();
    in_tvalid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // leaves psel high so back-to-back writes go straight into their setup phase
  task automatic cfg_write(input int reg_index, input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 6'(reg_index * scan_regs_pkg::REG_STRIDE);
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_config(input logic [5:0] len_value, input logic [47:0] care);
    logic [63:0] sig_word;
    settle();
    for (int r = 0; r < mssc_pkg::SIG_REGS; r++) begin
      for (int j = 0; j < 8; j++) sig_word[j*8 +: 8] = sig_pat[r*8 + j];
      cfg_write(scan_regs_pkg::REG_SIG_FIRST + r, sig_word);
    end
    // unused upper bits carry junk, the block must ignore them
    cfg_write(scan_regs_pkg::REG_CARE, {16'($urandom), care});
    cfg_write(scan_regs_pkg::REG_LEN, {26'($urandom), $urandom, len_value});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    care_now = care;
    if (len_value == 6'd0)
      sig_len = 1;
    else if (len_value > mssc_pkg::SIG_BYTES)
      sig_len = mssc_pkg::SIG_BYTES;
    else
      sig_len = int'(len_value);
  endtask

  initial begin
    logic [7:0]  region [REGION_MAX];
    logic [5:0]  len_value;
    logic [47:0] care;
    int          rlen;
    int          plants;
    int          at;
    int          k_bad;
    int          phase_end;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset signature, region shorter than the window, address crossing zero
    next_addr = 48'hFFFF_FFFF_FFFE;
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);

    // zero length acts as a one byte signature
    foreach (sig_pat[i]) sig_pat[i] = 8'h00;
    sig_pat[0] = 8'hFF;
    load_config(6'd0, '1);
    next_addr = 48'h0;
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    next_addr = 48'hFFFF_FFFF_FFFF;
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);

    // wildcard in the second position, match start wraps below zero
    sig_pat[0] = 8'hAA;
    sig_pat[1] = 8'hBB;
    sig_pat[2] = 8'hCC;
    sig_pat[3] = 8'hDD;
    load_config(6'd4, 48'hFFFF_FFFF_FFFD);
    next_addr = 48'hFFFF_FFFF_FFFE;
    push_byte(8'hAA, 1'b0);
    push_byte(8'h77, 1'b0);
    push_byte(8'hCC, 1'b0);
    push_byte(8'hDD, 1'b1);

    bytes_sent = 0;
    for (int phase = 0; bytes_sent < RANDOM_BYTES; phase++) begin
      if (bytes_sent >= 2 * RANDOM_BYTES / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (bytes_sent >= RANDOM_BYTES / 3) begin
        send_idle = 52;
        recv_idle = 24;
      end
      foreach (sig_pat[i]) sig_pat[i] = 8'($urandom);
      care = {16'($urandom), $urandom};
      case (phase % 8)
        0: begin
          len_value = 6'($urandom_range(1, 4));
          care      = '1;
        end
        1: len_value = 6'($urandom_range(2, 8));
        2: len_value = 6'd48;
        3: len_value = 6'($urandom_range(9, 20));
        4: begin
          // all wildcards: every complete window matches
          len_value = 6'($urandom_range(1, 6));
          care      = '0;
        end
        5: len_value = 6'd63;
        6: begin
          len_value = 6'd0;
          care      = '1;
        end
        default: begin
          len_value = 6'($urandom_range(2, 6));
          care[0]   = 1'b0;
        end
      endcase
      load_config(len_value, care);

      phase_end = bytes_sent + 60;
      while (bytes_sent < phase_end && bytes_sent < RANDOM_BYTES) begin
        rlen = $urandom_range(1, sig_len + 12);
        // filler leans on signature bytes so near misses are common
        for (int i = 0; i < rlen; i++)
          region[i] = $urandom_range(1) ? sig_pat[$urandom_range(sig_len - 1)] : 8'($urandom);
        if (rlen >= sig_len) begin
          plants = $urandom_range(3);
          for (int p = 0; p < plants; p++) begin
            at = $urandom_range(rlen - sig_len);
            for (int k = 0; k < sig_len; k++)
              if (care_now[k]) region[at + k] = sig_pat[k];
            // broken copy: one byte spoiled, no effect if it falls on a wildcard
            if ($urandom_range(3) == 0) begin
              k_bad = $urandom_range(sig_len - 1);
              region[at + k_bad] = ~region[at + k_bad];
            end
          end
        end
        if ($urandom_range(4) == 0)
          next_addr = 48'h0 - 48'($urandom_range(20));
        else
          next_addr = {16'($urandom), $urandom};
        for (int i = 0; i < rlen; i++) push_byte(region[i], i == rlen - 1);
        if ($urandom_range(11) == 0) settle();
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
